@@ hdl/sfmr_pkg.sv @@
// Shared types and constants for the stream first-match replace block.
// Used by sfmr_cell and stream_first_match_replace_core; no dependencies.
package sfmr_pkg;

  // Default window depth, which is the longest pattern the block accepts.
  localparam int MAX_PATTERN_DEF = 16;

  // Replacement storage is fixed at sixteen bytes.
  localparam int REPL_CAP = 16;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [2:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [2:0] CFG_REPLACE_LOW  = 3'd2;
  localparam logic [2:0] CFG_REPLACE_HIGH = 3'd3;
  localparam logic [2:0] CFG_PATTERN_LEN  = 3'd4;
  localparam logic [2:0] CFG_REPLACE_LEN  = 3'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPL,
    ST_FLUSH
  } state_t;

  // Control that the sequencer broadcasts to every window cell.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ hdl/stream_first_match_replace_core.sv @@
// Top level of the stream first-match replace block: configuration registers,
// the window cell chain and the output sequencer. Depends on sfmr_pkg, sfmr_cell.
//
// Replaces the leftmost occurrence of a configured byte pattern (1 to
// MAX_PATTERN bytes) with a configured replacement (0 to 16 bytes) and passes
// later bytes unchanged. An item is taken and is evaluated against the whole
// window in the next cycle; a match then sends each replacement byte, and the
// last item of a stream flushes each held-back byte. These flushed bytes leave
// the window one per cycle through the cell chain, and the replacement is read
// one byte per cycle, while the output port is not stalled. A stalled output
// port holds the sequencer. The final result of each stream carries out_last,
// and not_found when the pattern never matched, in which case everything sent
// for that stream must be dropped. Configuration is written only while the
// block is idle; the user must keep to this, the block itself does not enforce it.
module stream_first_match_replace_core
  import sfmr_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_last,
  output logic        not_found
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam logic [4:0] MaxLen = 5'(MAX_PATTERN);
  localparam logic [4:0] ReplCap = 5'(REPL_CAP);

  // Configuration registers.
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [63:0] replace_low;
  logic [63:0] replace_high;
  logic [4:0]  pattern_len;
  logic [4:0]  replace_len;

  // Sequencer state.
  state_t      state;
  state_t      state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic        match_done;
  logic        match_next;
  logic        last_pend;
  logic        last_next;
  logic [3:0]  rep_idx;
  logic [3:0]  rep_next;

  // Emission request toward the output register.
  logic        emit;
  logic        emit_ok;
  logic [7:0]  e_byte;
  logic        e_bv;
  logic        e_last;
  logic        e_nf;

  cell_ctl_t   ctl;
  logic [127:0] pat_word;
  logic [127:0] rep_word;
  logic [CW-1:0] p_eff;
  logic [4:0]  r_eff;
  logic [7:0]  rep_byte;
  logic        rep_last;
  logic        hit;

  logic [7:0]  cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_eq;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      replace_low  <= '0;
      replace_high <= '0;
      pattern_len  <= 5'd1;
      replace_len  <= 5'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low  <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high <= cfg_data;
        CFG_REPLACE_LOW:  replace_low  <= cfg_data;
        CFG_REPLACE_HIGH: replace_high <= cfg_data;
        CFG_PATTERN_LEN:  pattern_len  <= cfg_data[4:0];
        CFG_REPLACE_LEN:  replace_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective lengths: a zero pattern counts as one byte, and both are clamped.
  always_comb begin
    logic [4:0] p5;
    p5 = pattern_len;
    if (p5 == 5'd0) begin
      p5 = 5'd1;
    end
    if (p5 > MaxLen) begin
      p5 = MaxLen;
    end
    p_eff = CW'(p5);
    r_eff = (replace_len > ReplCap) ? ReplCap : replace_len;
  end

  assign pat_word = {pattern_high, pattern_low};
  assign rep_word = {replace_high, replace_low};
  assign rep_byte = rep_word[8*rep_idx +: 8];
  assign rep_last = ({1'b0, rep_idx} == (r_eff - 5'd1));

  // Window cell chain; cell zero holds the oldest byte.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] nb;
    if (i == MAX_PATTERN - 1) begin : g_end
      assign nb = 8'd0;
    end else begin : g_mid
      assign nb = cell_byte[i+1];
    end
    sfmr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (count == CW'(i)),
      .data_byte (data_byte),
      .next_byte (nb),
      .pat_byte  (pat_word[8*i +: 8]),
      .active    (CW'(i) < p_eff),
      .held      (cell_byte[i]),
      .eq        (cell_eq[i])
    );
  end

  // A match needs a full window of exactly the pattern length.
  assign hit = (count == p_eff) && (&cell_eq);

  assign in_ready = (state == ST_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      match_done <= 1'b0;
      last_pend  <= 1'b0;
      rep_idx    <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      match_done <= match_next;
      last_pend  <= last_next;
      rep_idx    <= rep_next;
    end
  end

  // Next state and emission.
  always_comb begin
    state_next = state;
    count_next = count;
    match_next = match_done;
    last_next  = last_pend;
    rep_next   = rep_idx;
    ctl        = '0;
    emit       = 1'b0;
    e_byte     = cell_byte[0];
    e_bv       = 1'b1;
    e_last     = 1'b0;
    e_nf       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          count_next = count + CW'(1);
          last_next  = last_byte;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (match_done) begin
          // Pass-through after the match.
          if (emit_ok) begin
            emit       = 1'b1;
            ctl.shift  = 1'b1;
            count_next = count - CW'(1);
            e_last     = last_pend;
            state_next = ST_IDLE;
            if (last_pend) begin
              match_next = 1'b0;
            end
          end
        end else if (hit) begin
          if (r_eff != 5'd0) begin
            count_next = '0;
            match_next = 1'b1;
            rep_next   = '0;
            state_next = ST_REPL;
          end else if (!last_pend) begin
            count_next = '0;
            match_next = 1'b1;
            state_next = ST_IDLE;
          end else if (emit_ok) begin
            // Deleted match on the final item leaves only a bare marker.
            emit       = 1'b1;
            e_byte     = 8'd0;
            e_bv       = 1'b0;
            e_last     = 1'b1;
            count_next = '0;
            match_next = 1'b0;
            state_next = ST_IDLE;
          end
        end else if (count >= p_eff) begin
          // Window full without a match: release the oldest byte.
          if (emit_ok) begin
            emit       = 1'b1;
            ctl.shift  = 1'b1;
            count_next = count - CW'(1);
            state_next = ST_IDLE;
            if (last_pend) begin
              if (count == CW'(1)) begin
                e_last = 1'b1;
                e_nf   = 1'b1;
              end else begin
                state_next = ST_FLUSH;
              end
            end
          end
        end else begin
          state_next = last_pend ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_REPL: begin
        if (emit_ok) begin
          emit     = 1'b1;
          e_byte   = rep_byte;
          rep_next = rep_idx + 4'd1;
          if (rep_last) begin
            state_next = ST_IDLE;
            if (last_pend) begin
              e_last     = 1'b1;
              match_next = 1'b0;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          emit       = 1'b1;
          ctl.shift  = 1'b1;
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            e_last     = 1'b1;
            e_nf       = !match_done;
            match_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register; it is loaded only when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= e_byte;
      byte_valid <= e_bv;
      out_last   <= e_last;
      not_found  <= e_nf;
    end
  end

  // The window never holds more bytes than it has cells.
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PATTERN))
    else $error("window count exceeds the cell count");

  // After a match the window stays empty between items.
  assert property (@(posedge clk) disable iff (rst)
    (match_done && state == ST_IDLE) |-> (count == '0))
    else $error("window not empty after match");

  // Replacement bytes go out only after a recorded match with an empty window.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPL) |-> (match_done && count == '0))
    else $error("replacement without a match");

  // A flush always has at least one byte to send.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (count != '0))
    else $error("flush with an empty window");

  // An accepted item is evaluated in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EVAL))
    else $error("accepted item not evaluated");

endmodule

@@ hdl/sfmr_cell.sv @@
// One cell of the held-back byte window: stores a byte, compares it with its
// pattern byte and takes its neighbor's byte on a shift. Depends on sfmr_pkg.
module sfmr_cell
  import sfmr_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  logic [7:0] data_byte,
  input  logic [7:0] next_byte,
  input  logic [7:0] pat_byte,
  input  logic      active,
  output logic [7:0] held,
  output logic      eq
);

  // The window moves toward cell zero on a shift; a load writes the new item.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= next_byte;
    end else if (ctl.load && sel) begin
      held <= data_byte;
    end
  end

  // Cells beyond the pattern length never block a match.
  assign eq = !active || (held == pat_byte);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking regression bench for stream_first_match_replace_core: directed and
// random byte streams checked against an in-bench first-match replace predictor.
// Depends on sfmr_pkg and the core RTL.
module tb;
  import sfmr_pkg::*;

  // One byte offered to the block.
  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } stream_item_t;

  // One result item that the block should send.
  typedef struct packed {
    logic [7:0] val;
    logic       has_byte;
    logic       fin;
    logic       miss;
  } patch_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_PATTERN_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        out_last;
  logic        not_found;

  stream_first_match_replace_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last),
    .not_found  (not_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the configuration registers.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [63:0] rep_lo = '0;
  logic [63:0] rep_hi = '0;
  logic [4:0]  pat_len_r = 5'd1;
  logic [4:0]  rep_len_r = 5'd0;

  // Predictor copy of the block state.
  logic [7:0]  win [MAX_PATTERN_DEF];
  int unsigned held_n = 0;
  bit          matched = 1'b0;

  stream_item_t feed_q [$];
  patch_out_t   patched_q [$];
  patch_out_t   want;
  stream_item_t nxt;

  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  logic        in_took = 1'b0;
  bit          idle_mode = 1'b0;
  int unsigned choke_req = 0;
  int unsigned choke_seen = 0;
  int unsigned choke_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // Symbols used to build near-miss streams and patterns.
  logic [7:0]  sym [3];
  bit          alpha_on = 1'b0;

  function automatic int unsigned eff_plen();
    if (pat_len_r == 5'd0) return 1;
    if (pat_len_r > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
    return pat_len_r;
  endfunction

  function automatic int unsigned eff_rlen();
    return (rep_len_r > REPL_CAP) ? REPL_CAP : rep_len_r;
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned i);
    logic [127:0] both;
    both = {pat_hi, pat_lo};
    return both[8*(i % 16) +: 8];
  endfunction

  function automatic logic [7:0] rep_byte(int unsigned i);
    logic [127:0] both;
    both = {rep_hi, rep_lo};
    return both[8*(i % 16) +: 8];
  endfunction

  function automatic logic [7:0] pick_sym();
    if (alpha_on && $urandom_range(0, 4) != 0) return sym[$urandom_range(0, 2)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic emit_byte(logic [7:0] v, logic hb);
    patched_q.push_back('{val: v, has_byte: hb, fin: 1'b0, miss: 1'b0});
  endtask

  // Work out the result items caused by one accepted input item.
  task automatic patch_step(logic [7:0] b, logic fin);
    int unsigned plen;
    int unsigned n;
    int unsigned i;
    int unsigned start;
    bit hit;
    patch_out_t tail;
    start = patched_q.size();
    if (matched) begin
      emit_byte(b, 1'b1);
    end else begin
      plen = eff_plen();
      n = (held_n > MAX_PATTERN_DEF - 1) ? MAX_PATTERN_DEF - 1 : held_n;
      win[n] = b;
      n++;
      // A window longer than a shortened pattern is never compared.
      hit = 1'b0;
      if (n == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++)
          if (win[i] != pat_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < eff_rlen(); i++) emit_byte(rep_byte(i), 1'b1);
        n = 0;
        matched = 1'b1;
      end else if (n >= plen) begin
        emit_byte(win[0], 1'b1);
        for (i = 0; i + 1 < n; i++) win[i] = win[i+1];
        n--;
      end
      held_n = n;
    end
    // End of stream: flush held bytes and tag the final result.
    if (fin) begin
      n = (held_n > MAX_PATTERN_DEF - 1) ? MAX_PATTERN_DEF - 1 : held_n;
      for (i = 0; i < n; i++) emit_byte(win[i], 1'b1);
      if (patched_q.size() == start) emit_byte(8'h00, 1'b0);
      tail = patched_q.pop_back();
      tail.fin = 1'b1;
      tail.miss = !matched;
      patched_q.push_back(tail);
      held_n = 0;
      matched = 1'b0;
    end
  endtask

  // Input driver: offers queued items, with random gaps when idling is on.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        nxt = feed_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.val;
        last_byte <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready: random stall bursts, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (choke_seen != choke_req) begin
        choke_seen = choke_req;
        choke_left = 80;
      end
      if (choke_left > 0) begin
        choke_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        items_taken++;
        patch_step(data_byte, last_byte);
      end
      if (out_valid && out_ready) begin
        if (patched_q.size() == 0) begin
          $error("unexpected result: out_byte 0x%02h byte_valid %0b out_last %0b not_found %0b",
                 out_byte, byte_valid, out_last, not_found);
          errors++;
        end else begin
          want = patched_q.pop_front();
          if (out_byte !== want.val) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.val, out_byte);
            errors++;
          end
          if (byte_valid !== want.has_byte) begin
            $error("byte_valid: expected %0b, actual %0b", want.has_byte, byte_valid);
            errors++;
          end
          if (out_last !== want.fin) begin
            $error("out_last: expected %0b, actual %0b", want.fin, out_last);
            errors++;
          end
          if (not_found !== want.miss) begin
            $error("not_found: expected %0b, actual %0b", want.miss, not_found);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_item(logic [7:0] v, logic f);
    feed_q.push_back('{val: v, fin: f});
    items_pushed++;
  endtask

  // Write one register and mirror it into the predictor once accepted.
  task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_LOW:  pat_lo = d;
      CFG_PATTERN_HIGH: pat_hi = d;
      CFG_REPLACE_LOW:  rep_lo = d;
      CFG_REPLACE_HIGH: rep_hi = d;
      CFG_PATTERN_LEN:  pat_len_r = d[4:0];
      CFG_REPLACE_LEN:  rep_len_r = d[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_apply(logic [63:0] pl, logic [63:0] ph, logic [63:0] rl,
                           logic [63:0] rh, logic [4:0] plen, logic [4:0] rlen);
    cfg_write(CFG_PATTERN_LOW, pl);
    cfg_write(CFG_PATTERN_HIGH, ph);
    cfg_write(CFG_REPLACE_LOW, rl);
    cfg_write(CFG_REPLACE_HIGH, rh);
    cfg_write(CFG_PATTERN_LEN, 64'(plen));
    cfg_write(CFG_REPLACE_LEN, 64'(rlen));
  endtask

  // Wait until every item is taken and every result has come, then let the
  // block settle, since held-back bytes produce nothing to wait on.
  task automatic wait_drained();
    do @(negedge clk); while (items_taken != items_pushed || patched_q.size() != 0);
    repeat (24) @(negedge clk);
  endtask

  // One stream: mostly prefix, pattern and suffix, sometimes plain noise.
  task automatic gen_stream();
    stream_item_t s [$];
    stream_item_t t;
    int unsigned plen;
    int unsigned cut;
    int unsigned i;
    plen = eff_plen();
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 8)) s.push_back('{val: pick_sym(), fin: 1'b0});
      // An aborted partial pattern right before the real one.
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, plen);
        for (i = 0; i < cut; i++) s.push_back('{val: pat_byte(i), fin: 1'b0});
      end
      if ($urandom_range(0, 7) != 0)
        for (i = 0; i < plen; i++) s.push_back('{val: pat_byte(i), fin: 1'b0});
      repeat ($urandom_range(0, 8)) s.push_back('{val: pick_sym(), fin: 1'b0});
    end else begin
      repeat ($urandom_range(1, 12))
        s.push_back('{val: 8'($urandom_range(0, 255)), fin: 1'b0});
    end
    if (s.size() == 0) s.push_back('{val: pick_sym(), fin: 1'b0});
    t = s.pop_back();
    t.fin = 1'b1;
    s.push_back(t);
    foreach (s[j]) push_item(s[j].val, s[j].fin);
  endtask

  // Test sequence.
  initial begin
    logic [127:0] pat_w;
    logic [4:0]   plen_w;
    logic [4:0]   rlen_w;
    int unsigned  mark;
    int unsigned  i;
    int unsigned  ph;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: one-byte pattern 0x00, deleted on match.
    push_item(8'h5A, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    wait_drained();

    // Longest pattern and replacement, match on the final byte, then a
    // stream shorter than the pattern.
    cfg_apply(64'h00FF_7E81_3CC3_A55A, 64'hFF00_1248_EDB7_6996,
              64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd16, 5'd16);
    for (i = 0; i < 16; i++) push_item(pat_byte(i), i == 15);
    push_item(8'h11, 1'b0);
    push_item(8'h22, 1'b1);
    wait_drained();

    // Pattern length zero acts as one; replacement length above the cap.
    cfg_apply(64'h0000_0000_0000_00FF, 64'(0), 64'h8899_AABB_CCDD_EEFF,
              64'h7766_5544_3322_1100, 5'd0, 5'd31);
    push_item(8'hFF, 1'b1);
    wait_drained();
    // Pattern length above the maximum, longer than the stream.
    cfg_write(CFG_PATTERN_LEN, 64'd31);
    push_item(8'h00, 1'b1);
    wait_drained();

    // Pattern shortened while bytes are held back.
    cfg_write(CFG_PATTERN_LEN, 64'd4);
    push_item(8'h01, 1'b0);
    push_item(8'h02, 1'b0);
    push_item(8'h03, 1'b0);
    wait_drained();
    cfg_write(CFG_PATTERN_LEN, 64'd1);
    push_item(8'hFF, 1'b1);
    wait_drained();

    // Long output hold-off while the input keeps offering pass-through bytes.
    idle_mode = 1'b0;
    cfg_apply(64'h0000_0000_0000_0042, 64'(0), 64'h0000_0000_00C0_FFEE, 64'(0), 5'd1, 5'd3);
    choke_req++;
    push_item(8'h42, 1'b0);
    for (i = 0; i < 50; i++) push_item(8'($urandom_range(0, 255)), i == 49);
    wait_drained();

    // Random phases, each with its own settings; the last two run without idling.
    for (ph = 0; ph < 12; ph++) begin
      idle_mode = (ph < 10) && ($urandom_range(0, 3) != 0);
      alpha_on = $urandom_range(0, 2) != 0;
      for (i = 0; i < 3; i++) sym[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < 16; i++)
        pat_w[8*i +: 8] = alpha_on ? sym[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0: plen_w = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
        1: plen_w = 5'd16;
        default: plen_w = 5'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0: rlen_w = 5'($urandom_range(17, 31));
        1: rlen_w = 5'd16;
        default: rlen_w = 5'($urandom_range(0, 8));
      endcase
      cfg_apply(pat_w[63:0], pat_w[127:64], {$urandom, $urandom}, {$urandom, $urandom},
                plen_w, rlen_w);
      mark = items_pushed;
      while (items_pushed - mark < 16) gen_stream();
      // Sometimes leave a stream open across the next settings change.
      if (ph < 11 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) push_item(pick_sym(), 1'b0);
      wait_drained();
    end

    if (errors == 0 && patched_q.size() == 0)
      $display("stream_first_match_replace_core regression: pass");
    else
      $display("stream_first_match_replace_core regression: fail");
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("stream_first_match_replace_core regression: fail");
    $finish;
  end

endmodule
